[src/ois_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ois_pkg;

    // Item field widths
    localparam int OP_W     = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam int DEFAULT_CAPACITY = 16;

    // Opcodes
    localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

endpackage

`default_nettype wire

[src/ordered_int_set_table.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                  Payload
// input     i_in_valid / o_in_ready    i_opcode, i_value
// output    o_out_valid / i_out_ready  o_status, o_found, o_count
//
// One item at a time. Find/insert/remove scan the stored entries through the
// single memory read port, one entry per cycle. Remove then compacts, one
// entry moved per cycle. Every item also passes through accept and result
// steps; clear has no scan. Reset clears the state, the count and the
// valid flags; entries are never read before being written. A stalled output
// holds one finished result while the next item is accepted; the next result
// waits until that slot frees.
module ordered_int_set_table #(
    parameter int CAPACITY = ois_pkg::DEFAULT_CAPACITY
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [ois_pkg::OP_W-1:0]      i_opcode,
    input  wire logic signed [ois_pkg::VALUE_W-1:0] i_value,
    // output channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [ois_pkg::STATUS_W-1:0]       o_status,
    output logic                               o_found,
    output logic [ois_pkg::COUNT_W-1:0]        o_count
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // Sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]                      r_state, n_state;
    logic [CW-1:0]                   r_count, n_count;
    logic [CW-1:0]                   r_rd_idx, n_rd_idx;   // next address to read
    logic [AW-1:0]                   r_cmp_idx, n_cmp_idx; // address of data on read port
    logic                            r_cmp_vld, n_cmp_vld;
    logic [ois_pkg::OP_W-1:0]        r_op, n_op;
    logic [ois_pkg::VALUE_W-1:0]     r_value, n_value;
    logic [ois_pkg::STATUS_W-1:0]    r_status, n_status;
    logic                            r_found, n_found;

    // Output slot
    logic                            r_out_valid, n_out_valid;
    logic [ois_pkg::STATUS_W-1:0]    r_out_status, n_out_status;
    logic                            r_out_found, n_out_found;
    logic [ois_pkg::COUNT_W-1:0]     r_out_count, n_out_count;

    // Memory port
    logic                            mem_wr_en;
    logic [AW-1:0]                   mem_wr_addr;
    logic [ois_pkg::VALUE_W-1:0]     mem_wr_data;
    logic                            mem_rd_en;
    logic [AW-1:0]                   mem_rd_addr;
    logic [ois_pkg::VALUE_W-1:0]     mem_rd_data;

    logic hit;
    logic more;
    logic out_free;

    ois_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (ois_pkg::VALUE_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_found     = r_out_found;
    assign o_count     = r_out_count;

    assign hit      = r_cmp_vld && (mem_rd_data == r_value);
    assign more     = (r_rd_idx < r_count);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_rd_idx     = r_rd_idx;
        n_cmp_idx    = r_cmp_idx;
        n_cmp_vld    = 1'b0;
        n_op         = r_op;
        n_value      = r_value;
        n_status     = r_status;
        n_found      = r_found;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_count  = r_out_count;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = r_count[AW-1:0];
        mem_wr_data  = r_value;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = r_rd_idx[AW-1:0];

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = i_opcode;
                    n_value  = i_value;
                    n_rd_idx = '0;
                    n_status = ois_pkg::ST_DONE;
                    n_found  = 1'b0;
                    if (i_opcode == ois_pkg::OP_CLEAR) begin
                        n_count = '0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                if (hit) begin
                    n_found = 1'b1;
                    unique case (r_op)
                        ois_pkg::OP_INSERT: begin
                            n_status = ois_pkg::ST_PRESENT;
                            n_state  = S_DONE;
                        end
                        ois_pkg::OP_REMOVE: begin
                            // compact: move entries pos+1.. down by one
                            n_rd_idx = CW'(r_cmp_idx) + CW'(1);
                            n_state  = S_SHIFT;
                        end
                        default: begin
                            n_status = ois_pkg::ST_DONE;
                            n_state  = S_DONE;
                        end
                    endcase
                end else if (more) begin
                    mem_rd_en = 1'b1;
                    n_cmp_idx = r_rd_idx[AW-1:0];
                    n_cmp_vld = 1'b1;
                    n_rd_idx  = r_rd_idx + CW'(1);
                end else begin
                    // scan exhausted, value absent
                    n_state = S_DONE;
                    if (r_op == ois_pkg::OP_INSERT) begin
                        if (r_count >= CW'(CAPACITY)) begin
                            n_status = ois_pkg::ST_FULL;
                        end else begin
                            mem_wr_en = 1'b1;
                            n_count   = r_count + CW'(1);
                            n_status  = ois_pkg::ST_DONE;
                        end
                    end else begin
                        n_status = ois_pkg::ST_ABSENT;
                    end
                end
            end

            S_SHIFT: begin
                if (r_cmp_vld) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = r_cmp_idx - AW'(1);
                    mem_wr_data = mem_rd_data;
                end
                if (more) begin
                    mem_rd_en = 1'b1;
                    n_cmp_idx = r_rd_idx[AW-1:0];
                    n_cmp_vld = 1'b1;
                    n_rd_idx  = r_rd_idx + CW'(1);
                end else begin
                    n_count  = r_count - CW'(1);
                    n_status = ois_pkg::ST_DONE;
                    n_state  = S_DONE;
                end
            end

            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_found  = r_found;
                    n_out_count  = ois_pkg::COUNT_W'(r_count);
                    n_state      = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cmp_vld   <= n_cmp_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx     <= n_rd_idx;
        r_cmp_idx    <= n_cmp_idx;
        r_op         <= n_op;
        r_value      <= n_value;
        r_status     <= n_status;
        r_found      <= n_found;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_count  <= n_out_count;
    end

endmodule

`default_nettype wire

[src/ois_mem.sv]
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port entry store: one write, one registered read.
module ois_mem #(
    parameter int DEPTH = ois_pkg::DEFAULT_CAPACITY,
    parameter int WIDTH = ois_pkg::VALUE_W,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire
